### src/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Types and constants shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int COF_W      = PROD_W + 1;
    localparam int CMAG_W     = PROD_W;
    localparam int DET_W      = DATA_W + COF_W + 1;
    localparam int DMAG_W     = DET_W - 1;
    localparam int QUO_W      = DATA_W;
    localparam int NUM_W      = CMAG_W + 2 * FRAC_BITS;
    localparam int CMP_W      = DMAG_W + QUO_W;
    localparam int DIV_STAGES = QUO_W;
    localparam int N_ENT      = 9;

    localparam logic [QUO_W-1:0] SAT_MAX = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] SAT_MIN = {1'b1, {(QUO_W-1){1'b0}}};

    // cofactor i = a[0]*a[1] - a[2]*a[3], entries numbered row by row
    localparam int COF_IDX [N_ENT][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };
    localparam int DET_COF [3] = '{0, 3, 6};

    typedef struct packed {
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m13;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
        logic signed [DATA_W-1:0] m23;
        logic signed [DATA_W-1:0] m31;
        logic signed [DATA_W-1:0] m32;
        logic signed [DATA_W-1:0] m33;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] v11;
        logic signed [DATA_W-1:0] v12;
        logic signed [DATA_W-1:0] v13;
        logic signed [DATA_W-1:0] v21;
        logic signed [DATA_W-1:0] v22;
        logic signed [DATA_W-1:0] v23;
        logic signed [DATA_W-1:0] v31;
        logic signed [DATA_W-1:0] v32;
        logic signed [DATA_W-1:0] v33;
        logic                     singular;
        logic                     overflow;
    } t_out;

    typedef struct packed {
        logic [DMAG_W-1:0] rem;
        logic [QUO_W-1:0]  low;
        logic [QUO_W-1:0]  quo;
        logic              neg;
        logic              ovf;
    } t_lane;

    typedef struct packed {
        t_lane [N_ENT-1:0] lane;
        logic [DMAG_W-1:0] dmag;
        logic              sing;
    } t_div;

endpackage

### src/matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Pipelined 3x3 inverse of a signed fixed-point matrix by adjugate over
// determinant, truncated toward zero and saturated, with singular and
// overflow flags.
//
// Input channel: i_valid / o_ready with i_data carrying the nine entries.
// Output channel: o_valid / i_ready with o_data carrying the nine inverse
// entries and the flags. One transaction in gives one transaction out.
// The pipeline has six stages of products, cofactors, determinant
// and magnitudes, one stage of divider setup, 32 restoring divider
// stages (one quotient bit each, one per lane) and the output register.
// Throughput is one matrix per cycle while the receiver does not stall.
// Reset clears every valid bit; no data is held across reset.
// When the receiver stalls with a result waiting, the whole pipeline
// holds, o_ready drops, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mi3_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output mi3_pkg::t_out  o_data
);
    import mi3_pkg::*;

    function automatic t_lane div_step(t_lane l, logic [DMAG_W-1:0] d);
        logic [DMAG_W:0] trial;
        t_lane           r;
        r     = l;
        trial = {l.rem, l.low[QUO_W-1]};
        if (trial >= {1'b0, d}) begin
            r.rem = DMAG_W'(trial - {1'b0, d});
            r.quo = {l.quo[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = trial[DMAG_W-1:0];
            r.quo = {l.quo[QUO_W-2:0], 1'b0};
        end
        r.low = {l.low[QUO_W-2:0], 1'b0};
        return r;
    endfunction

    // {overflow, value}
    function automatic logic [QUO_W:0] finish(t_lane l);
        logic [QUO_W:0] r;
        if (l.ovf) begin
            r = {1'b1, (l.neg ? SAT_MIN : SAT_MAX)};
        end else if (l.neg) begin
            if (l.quo > SAT_MIN) begin
                r = {1'b1, SAT_MIN};
            end else begin
                r = {1'b0, QUO_W'(-l.quo)};
            end
        end else if (l.quo[QUO_W-1]) begin
            r = {1'b1, SAT_MAX};
        end else begin
            r = {1'b0, l.quo};
        end
        return r;
    endfunction

    logic                      w_en;
    logic signed [DATA_W-1:0]  w_a [N_ENT];

    logic                      r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic signed [PROD_W-1:0]  r_p  [2*N_ENT];
    logic signed [DATA_W-1:0]  r_a1 [3];
    logic signed [DATA_W-1:0]  r_a2 [3];
    logic signed [COF_W-1:0]   r_c  [N_ENT];
    logic signed [COF_W-1:0]   r_pl [3];
    logic signed [COF_W-1:0]   r_ph [3];
    logic signed [DET_W-1:0]   r_t4 [3];
    logic signed [DET_W-1:0]   r_det;
    logic [DMAG_W-1:0]         r_dmag;
    logic                      r_dneg;
    logic                      r_sing;
    logic [CMAG_W-1:0]         r_cmag3 [N_ENT];
    logic [CMAG_W-1:0]         r_cmag4 [N_ENT];
    logic [CMAG_W-1:0]         r_cmag5 [N_ENT];
    logic [CMAG_W-1:0]         r_cmag6 [N_ENT];
    logic [N_ENT-1:0]          r_cneg3, r_cneg4, r_cneg5, r_cneg6;
    logic                      r_vd  [DIV_STAGES+1];
    t_div                      r_div [DIV_STAGES+1];
    logic                      r_vo;
    t_out                      r_out;
    t_div                      n_div0;
    t_out                      n_out;

    assign w_en    = !r_vo || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vo;
    assign o_data  = r_out;

    assign w_a[0] = i_data.m11;
    assign w_a[1] = i_data.m12;
    assign w_a[2] = i_data.m13;
    assign w_a[3] = i_data.m21;
    assign w_a[4] = i_data.m22;
    assign w_a[5] = i_data.m23;
    assign w_a[6] = i_data.m31;
    assign w_a[7] = i_data.m32;
    assign w_a[8] = i_data.m33;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_vo <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_v6    <= r_v5;
            r_vd[0] <= r_v6;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_vd[k+1] <= r_vd[k];
            end
            r_vo <= r_vd[DIV_STAGES];
        end
    end

    // products, cofactors, determinant, magnitudes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < N_ENT; i++) begin
                r_p[2*i]   <= w_a[COF_IDX[i][0]] * w_a[COF_IDX[i][1]];
                r_p[2*i+1] <= w_a[COF_IDX[i][2]] * w_a[COF_IDX[i][3]];
            end
            for (int k = 0; k < 3; k++) begin
                r_a1[k] <= w_a[k];
                r_a2[k] <= r_a1[k];
            end
            for (int i = 0; i < N_ENT; i++) begin
                r_c[i] <= COF_W'(r_p[2*i]) - COF_W'(r_p[2*i+1]);
            end
            for (int k = 0; k < 3; k++) begin
                r_pl[k] <= r_a2[k] * $signed({1'b0, r_c[DET_COF[k]][DATA_W-1:0]});
                r_ph[k] <= r_a2[k] * $signed(r_c[DET_COF[k]][COF_W-1:DATA_W]);
                r_t4[k] <= (DET_W'(r_ph[k]) <<< DATA_W) + DET_W'(r_pl[k]);
            end
            for (int i = 0; i < N_ENT; i++) begin
                r_cmag3[i] <= r_c[i][COF_W-1] ? CMAG_W'(-r_c[i]) : CMAG_W'(r_c[i]);
                r_cneg3[i] <= r_c[i][COF_W-1];
                r_cmag4[i] <= r_cmag3[i];
                r_cmag5[i] <= r_cmag4[i];
                r_cmag6[i] <= r_cmag5[i];
            end
            r_cneg4 <= r_cneg3;
            r_cneg5 <= r_cneg4;
            r_cneg6 <= r_cneg5;
            r_det   <= r_t4[0] + r_t4[1] + r_t4[2];
            r_dmag  <= r_det[DET_W-1] ? DMAG_W'(-r_det) : DMAG_W'(r_det);
            r_dneg  <= r_det[DET_W-1];
            r_sing  <= (r_det == '0);
        end
    end

    // divider setup
    always_comb begin
        logic [NUM_W-1:0] num;
        n_div0      = '0;
        n_div0.dmag = r_dmag;
        n_div0.sing = r_sing;
        for (int i = 0; i < N_ENT; i++) begin
            num                 = NUM_W'(r_cmag6[i]) << (2 * FRAC_BITS);
            n_div0.lane[i].ovf  = CMP_W'(num) >= (CMP_W'(r_dmag) << QUO_W);
            n_div0.lane[i].rem  = DMAG_W'(num >> QUO_W);
            n_div0.lane[i].low  = num[QUO_W-1:0];
            n_div0.lane[i].quo  = '0;
            n_div0.lane[i].neg  = r_cneg6[i] ^ r_dneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_div[0] <= n_div0;
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_div[g+1].dmag <= r_div[g].dmag;
                r_div[g+1].sing <= r_div[g].sing;
                for (int i = 0; i < N_ENT; i++) begin
                    r_div[g+1].lane[i] <= div_step(r_div[g].lane[i], r_div[g].dmag);
                end
            end
        end
    end

    // sign, saturation and flags
    always_comb begin
        logic [QUO_W:0]   f [N_ENT];
        logic [N_ENT-1:0] ov;
        for (int i = 0; i < N_ENT; i++) begin
            f[i]  = finish(r_div[DIV_STAGES].lane[i]);
            ov[i] = f[i][QUO_W];
        end
        n_out.v11      = $signed(f[0][QUO_W-1:0]);
        n_out.v12      = $signed(f[1][QUO_W-1:0]);
        n_out.v13      = $signed(f[2][QUO_W-1:0]);
        n_out.v21      = $signed(f[3][QUO_W-1:0]);
        n_out.v22      = $signed(f[4][QUO_W-1:0]);
        n_out.v23      = $signed(f[5][QUO_W-1:0]);
        n_out.v31      = $signed(f[6][QUO_W-1:0]);
        n_out.v32      = $signed(f[7][QUO_W-1:0]);
        n_out.v33      = $signed(f[8][QUO_W-1:0]);
        n_out.singular = 1'b0;
        n_out.overflow = |ov;
        if (r_div[DIV_STAGES].sing) begin
            n_out          = '0;
            n_out.singular = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

endmodule

### tb/matrix_inverse_3x3_tb.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_tb
// Drives matrices through the 3x3 inverse pipeline with bursty input and a
// stalling receiver, predicts each inverse at full width and checks every
// result transaction field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_inverse_3x3_tb;
    import mi3_pkg::*;

    localparam int N_RANDOM = 530;
    localparam longint CYCLE_LIMIT = 400000;

    class inverse_scoreboard;
        t_out expected_q[$];
        int   n_errors;
        int   n_checked;
        int   n_singular;
        int   n_saturated;

        function automatic logic signed [127:0] cofactor(logic signed [127:0] a,
                logic signed [127:0] d, logic signed [127:0] b, logic signed [127:0] c);
            return a * d - b * c;
        endfunction

        function automatic logic [31:0] scaled_quotient(logic signed [127:0] c,
                logic signed [127:0] det, ref logic sat);
            logic               neg;
            logic [127:0]       num;
            logic [127:0]       den;
            logic [127:0]       q;
            neg = c[127] ^ det[127];
            num = c[127] ? -c : c;
            den = det[127] ? -det : det;
            num = num << (2 * FRAC_BITS);
            q = num / den;
            if (neg) begin
                if (q > 128'h8000_0000) begin
                    sat = 1'b1;
                    return SAT_MIN;
                end
                return 32'(-q);
            end
            if (q > 128'h7FFF_FFFF) begin
                sat = 1'b1;
                return SAT_MAX;
            end
            return q[31:0];
        endfunction

        function void note_matrix(t_in m);
            logic signed [127:0] a [9];
            logic signed [127:0] cf [9];
            logic signed [127:0] det;
            logic [31:0]         v [9];
            logic                sat;
            t_out                r;
            a = '{m.m11, m.m12, m.m13, m.m21, m.m22, m.m23, m.m31, m.m32, m.m33};
            cf[0] = cofactor(a[4], a[8], a[5], a[7]);
            cf[1] = cofactor(a[2], a[7], a[1], a[8]);
            cf[2] = cofactor(a[1], a[5], a[2], a[4]);
            cf[3] = cofactor(a[5], a[6], a[3], a[8]);
            cf[4] = cofactor(a[0], a[8], a[2], a[6]);
            cf[5] = cofactor(a[2], a[3], a[0], a[5]);
            cf[6] = cofactor(a[3], a[7], a[4], a[6]);
            cf[7] = cofactor(a[1], a[6], a[0], a[7]);
            cf[8] = cofactor(a[0], a[4], a[1], a[3]);
            det = a[0] * cf[0] + a[1] * cf[3] + a[2] * cf[6];
            sat = 1'b0;
            if (det == 0) begin
                r = '0;
                r.singular = 1'b1;
                n_singular++;
            end else begin
                for (int i = 0; i < 9; i++) v[i] = scaled_quotient(cf[i], det, sat);
                r = '{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], 1'b0, sat};
                if (sat) n_saturated++;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out e;
            n_checked++;
            if (expected_q.size() == 0) begin
                $error("result transaction with nothing expected");
                n_errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.v11 !== e.v11) begin $error("v11 exp %h got %h", e.v11, got.v11); n_errors++; end
            if (got.v12 !== e.v12) begin $error("v12 exp %h got %h", e.v12, got.v12); n_errors++; end
            if (got.v13 !== e.v13) begin $error("v13 exp %h got %h", e.v13, got.v13); n_errors++; end
            if (got.v21 !== e.v21) begin $error("v21 exp %h got %h", e.v21, got.v21); n_errors++; end
            if (got.v22 !== e.v22) begin $error("v22 exp %h got %h", e.v22, got.v22); n_errors++; end
            if (got.v23 !== e.v23) begin $error("v23 exp %h got %h", e.v23, got.v23); n_errors++; end
            if (got.v31 !== e.v31) begin $error("v31 exp %h got %h", e.v31, got.v31); n_errors++; end
            if (got.v32 !== e.v32) begin $error("v32 exp %h got %h", e.v32, got.v32); n_errors++; end
            if (got.v33 !== e.v33) begin $error("v33 exp %h got %h", e.v33, got.v33); n_errors++; end
            if (got.singular !== e.singular) begin
                $error("singular exp %b got %b", e.singular, got.singular);
                n_errors++;
            end
            if (got.overflow !== e.overflow) begin
                $error("overflow exp %b got %b", e.overflow, got.overflow);
                n_errors++;
            end
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_in   i_data;
    logic  o_valid;
    logic  i_ready;
    t_out  o_data;

    inverse_scoreboard sb;
    longint cycle_count = 0;
    int     stall_mode = 0;
    int     n_sent;

    matrix_inverse_3x3 DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial sb = new();

    // accepted transactions on both sides
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && i_valid && o_ready) sb.note_matrix(i_data);
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stall pattern, changes its character now and then
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 3) != 0);
                2: i_ready <= ($urandom_range(0, 1) != 0);
                default: i_ready <= (cycle_count[3:0] < 4'd3);
            endcase
        end
    end

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
            2: return 32'($signed($urandom_range(0, 512)) - 256);
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5: return 32'($signed($urandom_range(0, 131072)) - 65536) << $urandom_range(0, 12);
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic t_in rand_matrix();
        t_in m;
        m = '{rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
              rand_entry(), rand_entry(), rand_entry(), rand_entry()};
        case ($urandom_range(0, 9))
            0: m.m21 = m.m11 * 2;
            1: begin m.m31 = m.m11; m.m32 = m.m12; m.m33 = m.m13; end
            2: begin m.m13 = 0; m.m23 = 0; m.m33 = 0; end
            default: ;
        endcase
        return m;
    endfunction

    task automatic send_matrix(t_in m);
        i_valid <= 1'b1;
        i_data  <= m;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic idle_gap(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        t_in m;
        t_in directed[$];
        localparam logic [31:0] ONE = 32'h0001_0000;
        int burst;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        n_sent      = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity, scaled identities, zero, singular, extremes, tiny det
        directed.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
        directed.push_back('{-ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
        directed.push_back('{ONE * 2, 0, 0, 0, ONE * 4, 0, 0, 0, ONE / 2});
        directed.push_back('0);
        directed.push_back('{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
        directed.push_back('{1, 0, 0, 0, 1, 0, 0, 0, 1});
        directed.push_back('{-1, 0, 0, 0, 1, 0, 0, 0, -1});
        directed.push_back('{SAT_MIN, 0, 0, 0, SAT_MIN, 0, 0, 0, SAT_MIN});
        directed.push_back('{SAT_MAX, 0, 0, 0, SAT_MAX, 0, 0, 0, SAT_MAX});
        directed.push_back('{SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX,
                             SAT_MAX, SAT_MAX, SAT_MIN});
        directed.push_back('{SAT_MAX, SAT_MIN, 1, -1, SAT_MAX, 0, 3, SAT_MIN, SAT_MAX});
        directed.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF});
        directed.push_back('{ONE, ONE * 2, ONE * 3, 0, ONE, ONE * 4, ONE * 5, ONE * 6, 0});
        directed.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 7, 9, 32'h5555_5555, 32'hAAAA_AAAA,
                             32'hAAAA_AAAA, 11, 32'h5555_5555});
        directed.push_back('{2, 1, 0, 1, 2, 1, 0, 1, 2});
        directed.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0, 0});
        foreach (directed[i]) send_matrix(directed[i]);

        for (int i = 0; i < N_RANDOM; ) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && i < N_RANDOM; j++, i++) begin
                m = rand_matrix();
                send_matrix(m);
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
        end
        i_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("sent %0d matrices, checked %0d inverses", n_sent, sb.n_checked);
        $display("singular results %0d, saturated results %0d", sb.n_singular,
                 sb.n_saturated);
        if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
